// ===== rtl/rqwa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqwa_pkg
// Shared types and constants of the ring queue with worker autoscaler.
// ----------------------------------------------------------------------------
package rqwa_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  localparam int unsigned REQ_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned CAP_W = 5;
  localparam int unsigned WRK_W = 8;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned CAP_RESET = 16;
  localparam logic [WRK_W-1:0] WRK_LOW_RESET = 8'd1;
  localparam logic [WRK_W-1:0] WRK_HIGH_RESET = 8'd4;
  localparam logic [PCT_W-1:0] GROW_RESET = 7'd75;
  localparam logic [PCT_W-1:0] SHRINK_RESET = 7'd25;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT  = 2'd0,
    REQ_GET  = 2'd1,
    REQ_TICK = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 3'd0,
    CFG_WRK_LOW  = 3'd1,
    CFG_WRK_HIGH = 3'd2,
    CFG_GROW     = 3'd3,
    CFG_SHRINK   = 3'd4
  } cfg_e;

endpackage
`default_nettype wire

// ===== rtl/rqwa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rqwa_req_if / rqwa_rsp_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface rqwa_req_if
  import rqwa_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [REQ_W-1:0]       req_type;
  logic [HANDLE_BITS-1:0] item_handle;
  logic                   stop_marker;

  modport source (output valid, req_type, item_handle, stop_marker, input ready);
  modport sink   (input valid, req_type, item_handle, stop_marker, output ready);
endinterface

interface rqwa_rsp_if
  import rqwa_pkg::*;
#(
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [STAT_W-1:0]      status;
  logic [HANDLE_BITS-1:0] handle_out;
  logic                   handle_is_stop;
  logic [PCT_W-1:0]       fill_percent;
  logic [WRK_W-1:0]       worker_total;
  logic [ACT_W-1:0]       scale_action;

  modport source (output valid, status, handle_out, handle_is_stop, fill_percent,
                  worker_total, scale_action, input ready);
  modport sink   (input valid, status, handle_out, handle_is_stop, fill_percent,
                  worker_total, scale_action, output ready);
endinterface
`default_nettype wire

// ===== rtl/ring_queue_with_worker_autoscaler_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ring_queue_with_worker_autoscaler_core
// Circular job queue in a slot RAM with an occupancy-driven worker count.
//
// Channels: req_i takes put, get and monitor-tick beats; rsp_o returns one
// result beat per request. The user must write configuration through
// cfg_we_i, cfg_idx_i and cfg_data_i only while the block is idle; the
// block itself does not enforce this.
// Each request takes a slot RAM read on accept, a read-modify-write step,
// then the shift-subtract divider that forms count*100/capacity in two
// steps, four quotient bits per cycle, before the next request can be taken.
// The fill percent of the current count is kept in a register, so a tick
// needs only the divider pass for the count after the step.
// Reset: queue empty, one worker, capacity 16 (or the depth if smaller),
// limits 1 and 4, thresholds 75 and 25. The slot RAM is not cleared; only
// counted entries are ever read.
// Stall: a finished result sits in the output register; a further finished
// result waits in the block until the register frees, and no new request is
// taken meanwhile.
// ----------------------------------------------------------------------------
module ring_queue_with_worker_autoscaler_core
  import rqwa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  rqwa_req_if.sink                   req_i,
  rqwa_rsp_if.source                 rsp_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CapTop = (1 << CAP_W) - 1;
  localparam int unsigned CapLimit = (QUEUE_DEPTH < CapTop) ? QUEUE_DEPTH : CapTop;
  localparam int unsigned CapInit = (CAP_RESET < QUEUE_DEPTH) ? CAP_RESET : QUEUE_DEPTH;
  localparam int unsigned SLOT_W = HANDLE_BITS + 1;
  localparam int unsigned NUM_W = CAP_W + PCT_W;
  localparam int unsigned QUO_W = PCT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SLOT_W-1:0] slot_mem [QUEUE_DEPTH];
  logic [SLOT_W-1:0] rd_q;

  logic [CAP_W-1:0] cap_q, head_q, head_d, tail_q, tail_d, count_q, count_d;
  logic [WRK_W-1:0] wrk_q, wrk_d, low_q, high_q;
  logic [PCT_W-1:0] grow_q, shrink_q, fill_q;

  logic [REQ_W-1:0]       req_q;
  logic [HANDLE_BITS-1:0] hdl_q;
  logic                   stop_q;

  status_e                res_stat_q, res_stat_d;
  action_e                res_act_q, res_act_d;
  logic [HANDLE_BITS-1:0] res_hdl_q, res_hdl_d;
  logic                   res_stop_q, res_stop_d;

  logic [NUM_W-1:0] rem_q, rem_d, num_load;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic             iter_q;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_wdata;
  logic              in_acc, out_free, is_full, push;
  logic [CAP_W:0]    head_inc, tail_inc;
  logic [CAP_W-1:0]  cap_wr;

  logic                   out_valid_q;
  status_e                out_stat_q;
  logic [HANDLE_BITS-1:0] out_hdl_q;
  logic                   out_stop_q;
  logic [PCT_W-1:0]       out_fill_q;
  logic [WRK_W-1:0]       out_wrk_q;
  action_e                out_act_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_stat_q;
  assign rsp_o.handle_out     = out_hdl_q;
  assign rsp_o.handle_is_stop = out_stop_q;
  assign rsp_o.fill_percent   = out_fill_q;
  assign rsp_o.worker_total   = out_wrk_q;
  assign rsp_o.scale_action   = out_act_q;

  // capacity write clamped to 1..min(depth, 31)
  always_comb begin
    cap_wr = cfg_data_i[CAP_W-1:0];
    if (cap_wr == '0) begin
      cap_wr = CAP_W'(1);
    end else if (cap_wr > CAP_W'(CapLimit)) begin
      cap_wr = CAP_W'(CapLimit);
    end
  end

  // slot RAM: read at head on accept, write at tail in the exec cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= slot_mem[IDX_W'(head_q)];
    end
    if (mem_we) begin
      slot_mem[IDX_W'(tail_q)] <= mem_wdata;
    end
  end

  assign is_full  = (count_q >= cap_q);
  assign head_inc = {1'b0, head_q} + (CAP_W+1)'(1);
  assign tail_inc = {1'b0, tail_q} + (CAP_W+1)'(1);

  // read-modify-write of the queue state
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    wrk_d      = wrk_q;
    res_stat_d = ST_DONE;
    res_act_d  = ACT_NONE;
    res_hdl_d  = '0;
    res_stop_d = 1'b0;
    push       = 1'b0;
    mem_wdata  = {stop_q, stop_q ? {HANDLE_BITS{1'b0}} : hdl_q};
    case (req_q)
      REQ_PUT: begin
        if (is_full) begin
          res_stat_d = ST_FULL;
        end else begin
          push = 1'b1;
        end
      end
      REQ_GET: begin
        if (count_q == '0) begin
          res_stat_d = ST_EMPTY;
        end else begin
          res_hdl_d  = rd_q[HANDLE_BITS-1:0];
          res_stop_d = rd_q[HANDLE_BITS];
          head_d     = (head_inc >= {1'b0, cap_q}) ? '0 : head_inc[CAP_W-1:0];
          count_d    = count_q - CAP_W'(1);
        end
      end
      REQ_TICK: begin
        if (fill_q > grow_q && wrk_q < high_q) begin
          wrk_d     = wrk_q + WRK_W'(1);
          res_act_d = ACT_ADD;
        end else if (fill_q < shrink_q && wrk_q > low_q) begin
          if (is_full) begin
            res_stat_d = ST_FULL;
          end else begin
            push      = 1'b1;
            mem_wdata = {1'b1, {HANDLE_BITS{1'b0}}};
            wrk_d     = wrk_q - WRK_W'(1);
            res_act_d = ACT_REMOVE;
          end
        end
      end
      default: begin
      end
    endcase
    if (push) begin
      tail_d  = (tail_inc >= {1'b0, cap_q}) ? '0 : tail_inc[CAP_W-1:0];
      count_d = count_q + CAP_W'(1);
    end
  end

  assign mem_we   = (state_q == S_EXEC) && push;
  assign num_load = (NUM_W'(count_d) << 6) + (NUM_W'(count_d) << 5) + (NUM_W'(count_d) << 2);

  // four restoring steps of count*100/capacity per cycle
  always_comb begin
    logic [NUM_W-1:0] dvs;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int j = 0; j < 4; j++) begin
      dvs = {cap_q, {PCT_W{1'b0}}} >> {iter_q, 2'(j)};
      if (rem_d >= dvs) begin
        rem_d = rem_d - dvs;
        quo_d = {quo_d[QUO_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_EXEC;
      S_EXEC: state_d = S_DIV;
      S_DIV: begin
        if (iter_q) begin
          state_d = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cap_q    <= CAP_W'(CapInit);
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      fill_q   <= '0;
      wrk_q    <= WRK_LOW_RESET;
      low_q    <= WRK_LOW_RESET;
      high_q   <= WRK_HIGH_RESET;
      grow_q   <= GROW_RESET;
      shrink_q <= SHRINK_RESET;
      iter_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CAPACITY: begin
            cap_q   <= cap_wr;
            head_q  <= '0;
            tail_q  <= '0;
            count_q <= '0;
            fill_q  <= '0;
          end
          CFG_WRK_LOW: begin
            low_q <= cfg_data_i[WRK_W-1:0];
            wrk_q <= cfg_data_i[WRK_W-1:0];
          end
          CFG_WRK_HIGH: high_q   <= cfg_data_i[WRK_W-1:0];
          CFG_GROW:     grow_q   <= cfg_data_i[PCT_W-1:0];
          CFG_SHRINK:   shrink_q <= cfg_data_i[PCT_W-1:0];
          default: begin
          end
        endcase
      end else if (state_q == S_EXEC) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
        wrk_q   <= wrk_d;
      end
      if (state_q == S_EXEC) begin
        iter_q <= 1'b0;
      end else if (state_q == S_DIV) begin
        iter_q <= 1'b1;
        if (iter_q) begin
          fill_q <= quo_d[PCT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_i.req_type;
      hdl_q  <= req_i.item_handle;
      stop_q <= req_i.stop_marker;
    end
    if (state_q == S_EXEC) begin
      res_stat_q <= res_stat_d;
      res_act_q  <= res_act_d;
      res_hdl_q  <= res_hdl_d;
      res_stop_q <= res_stop_d;
      rem_q      <= num_load;
      quo_q      <= '0;
    end else if (state_q == S_DIV) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ((state_q == S_DIV) && iter_q) || (state_q == S_HOLD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && (((state_q == S_DIV) && iter_q) || (state_q == S_HOLD))) begin
      out_stat_q <= res_stat_q;
      out_hdl_q  <= res_hdl_q;
      out_stop_q <= res_stop_q;
      out_fill_q <= (state_q == S_HOLD) ? fill_q : quo_d[PCT_W-1:0];
      out_wrk_q  <= wrk_q;
      out_act_q  <= res_act_q;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ring queue with worker autoscaler. A directed
// table covers the corner cases: empty get, full put, stop tokens, clamped
// capacity writes, growth to the limit and a shrink that cannot fit. Random
// put, get and tick traffic follows in fill and drain bursts over many
// register settings. Every result beat is checked against its table row or a
// local queue and autoscaler predictor, under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench
  import rqwa_pkg::*;
();

  localparam logic [REQ_W-1:0] REQ_OTHER = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [REQ_W-1:0]           kind;
    logic [HANDLE_BITS_DEF-1:0] handle;
    logic                       stop;
  } request_t;

  typedef struct {
    status_e                    status;
    logic [HANDLE_BITS_DEF-1:0] handle;
    logic                       is_stop;
    logic [PCT_W-1:0]           fill;
    logic [WRK_W-1:0]           workers;
    action_e                    action;
  } result_t;

  typedef struct {
    bit                    is_cfg;
    cfg_e                  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    request_t              req;
    bit                    typed;
    result_t               want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rqwa_req_if req_if ();
  rqwa_rsp_if rsp_if ();

  ring_queue_with_worker_autoscaler_core dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #1 clk = ~clk;

  // queue and autoscaler shadow state
  logic [HANDLE_BITS_DEF-1:0] slot_handle [QUEUE_DEPTH_DEF];
  logic                       slot_stop   [QUEUE_DEPTH_DEF];
  int unsigned q_head = 0, q_tail = 0, q_count = 0, q_cap = CAP_RESET;
  int unsigned workers = WRK_LOW_RESET, wrk_low = WRK_LOW_RESET;
  int unsigned wrk_high = WRK_HIGH_RESET, grow_pct = GROW_RESET, shrink_pct = SHRINK_RESET;

  result_t   due_results [$];
  plan_row_t plan [$];

  int unsigned src_idle_pct = 30, snk_idle_pct = 82, hold_len = 0;
  int unsigned mismatches = 0, requests_sent = 0, results_seen = 0, reg_writes = 0;
  int unsigned n_full = 0, n_empty = 0, n_add = 0, n_remove = 0, n_no_room = 0;

  function automatic int unsigned next_slot(int unsigned i);
    return (i + 1 >= q_cap) ? 0 : i + 1;
  endfunction

  function automatic int unsigned fill_pct();
    return (q_count * 100) / q_cap;
  endfunction

  function automatic void enqueue(logic [HANDLE_BITS_DEF-1:0] h, logic stop);
    slot_handle[q_tail] = stop ? '0 : h;
    slot_stop[q_tail] = stop;
    q_tail = next_slot(q_tail);
    q_count++;
  endfunction

  function automatic result_t step_queue(request_t r);
    result_t o;
    int unsigned pct;
    o.status = ST_DONE;
    o.handle = '0;
    o.is_stop = 1'b0;
    o.action = ACT_NONE;
    case (r.kind)
      REQ_PUT: begin
        if (q_count >= q_cap) o.status = ST_FULL;
        else enqueue(r.handle, r.stop);
      end
      REQ_GET: begin
        if (q_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.handle = slot_handle[q_head];
          o.is_stop = slot_stop[q_head];
          q_head = next_slot(q_head);
          q_count--;
        end
      end
      REQ_TICK: begin
        pct = fill_pct();
        if (pct > grow_pct && workers < wrk_high) begin
          workers++;
          o.action = ACT_ADD;
        end else if (pct < shrink_pct && workers > wrk_low) begin
          if (q_count >= q_cap) begin
            o.status = ST_FULL;
          end else begin
            enqueue('0, 1'b1);
            workers--;
            o.action = ACT_REMOVE;
          end
        end
      end
      default: ;
    endcase
    o.fill = PCT_W'(fill_pct());
    o.workers = WRK_W'(workers);
    return o;
  endfunction

  function automatic request_t random_request(int unsigned mode);
    request_t r;
    int unsigned pick, put_lim, get_lim;
    put_lim = (mode == 0) ? 65 : (mode == 1) ? 15 : 40;
    get_lim = (mode == 0) ? 80 : 75;
    pick = $urandom_range(99);
    if (pick < put_lim) r.kind = REQ_PUT;
    else if (pick < get_lim) r.kind = REQ_GET;
    else if (pick < 97) r.kind = REQ_TICK;
    else r.kind = REQ_OTHER;
    case ($urandom_range(9))
      0: r.handle = '0;
      1: r.handle = '1;
      default: r.handle = $urandom;
    endcase
    r.stop = ($urandom_range(5) == 0);
    return r;
  endfunction

  function automatic void dir_op(logic [REQ_W-1:0] kind, logic [31:0] h, logic stop);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = CFG_CAPACITY;
    row.reg_val = '0;
    row.req.kind = kind;
    row.req.handle = h;
    row.req.stop = stop;
    row.typed = 1'b0;
    row.want.status = ST_DONE;
    row.want.handle = '0;
    row.want.is_stop = 1'b0;
    row.want.fill = '0;
    row.want.workers = '0;
    row.want.action = ACT_NONE;
    plan.push_back(row);
  endfunction

  function automatic void dir_chk(logic [REQ_W-1:0] kind, logic [31:0] h, logic stop,
                                  status_e st, logic [31:0] h_out, logic s_out,
                                  int unsigned fill, int unsigned w, action_e act);
    dir_op(kind, h, stop);
    plan[$].typed = 1'b1;
    plan[$].want.status = st;
    plan[$].want.handle = h_out;
    plan[$].want.is_stop = s_out;
    plan[$].want.fill = PCT_W'(fill);
    plan[$].want.workers = WRK_W'(w);
    plan[$].want.action = act;
  endfunction

  function automatic void dir_cfg(cfg_e idx, logic [CFG_DATA_W-1:0] val);
    dir_op(REQ_OTHER, '0, 1'b0);
    plan[$].is_cfg = 1'b1;
    plan[$].reg_idx = idx;
    plan[$].reg_val = val;
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 50)
      $display("tb: mismatch on %s after %0d results: expected 0x%0h, got 0x%0h",
               what, results_seen, want, got);
  endtask

  task automatic write_reg(cfg_e idx, logic [CFG_DATA_W-1:0] val);
    int unsigned c;
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_CAPACITY: begin
        c = val & 8'h1F;
        if (c == 0) c = 1;
        if (c > QUEUE_DEPTH_DEF) c = QUEUE_DEPTH_DEF;
        q_cap = c;
        q_head = 0;
        q_tail = 0;
        q_count = 0;
      end
      CFG_WRK_LOW: begin
        wrk_low = val;
        workers = val;
      end
      CFG_WRK_HIGH: wrk_high = val;
      CFG_GROW:     grow_pct = val & 8'h7F;
      CFG_SHRINK:   shrink_pct = val & 8'h7F;
      default: ;
    endcase
  endtask

  // drop valid and wait until every result beat is back
  task automatic settle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic push_req(request_t r, bit typed, result_t want);
    result_t exp;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= r.kind;
    req_if.item_handle <= r.handle;
    req_if.stop_marker <= r.stop;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    exp = step_queue(r);
    requests_sent++;
    if (exp.status == ST_FULL && r.kind == REQ_PUT) n_full++;
    if (exp.status == ST_FULL && r.kind == REQ_TICK) n_no_room++;
    if (exp.status == ST_EMPTY) n_empty++;
    if (exp.action == ACT_ADD) n_add++;
    if (exp.action == ACT_REMOVE) n_remove++;
    due_results.push_back(typed ? want : exp);
  endtask

  // result channel: random stalls, plus long hold-offs on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk);
        hold_len = 0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.status = status_e'(rsp_if.status);
      got.handle = rsp_if.handle_out;
      got.is_stop = rsp_if.handle_is_stop;
      got.fill = rsp_if.fill_percent;
      got.workers = rsp_if.worker_total;
      got.action = action_e'(rsp_if.scale_action);
      if (due_results.size() == 0) begin
        report("unexpected result beat, status", '0, got.status);
      end else begin
        want = due_results.pop_front();
        results_seen++;
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.handle !== want.handle) report("handle_out", want.handle, got.handle);
        if (got.is_stop !== want.is_stop) report("handle_is_stop", want.is_stop, got.is_stop);
        if (got.fill !== want.fill) report("fill_percent", want.fill, got.fill);
        if (got.workers !== want.workers) report("worker_total", want.workers, got.workers);
        if (got.action !== want.action) report("scale_action", want.action, got.action);
      end
    end
  end

  initial begin
    #1000000;
    $display("tb: timeout with %0d results outstanding", due_results.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    request_t blank_req;
    result_t  blank;
    logic [CFG_DATA_W-1:0] v_cap, v_low, v_high, v_grow, v_shrink;
    int unsigned burst_left, mode;
    blank_req.kind = REQ_PUT;
    blank_req.handle = '0;
    blank_req.stop = 1'b0;
    blank = step_queue(blank_req);
    q_head = 0;
    q_tail = 0;
    q_count = 0;
    burst_left = 0;
    mode = 0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_PUT;
    req_if.item_handle = '0;
    req_if.stop_marker = 1'b0;

    // directed table, from reset values
    dir_chk(REQ_GET, 32'h0, 1'b0, ST_EMPTY, '0, 1'b0, 0, 1, ACT_NONE);
    dir_chk(REQ_TICK, 32'h0, 1'b0, ST_DONE, '0, 1'b0, 0, 1, ACT_NONE);
    dir_chk(REQ_OTHER, 32'hFFFF_FFFF, 1'b1, ST_DONE, '0, 1'b0, 0, 1, ACT_NONE);
    dir_op(REQ_PUT, 32'hFFFF_FFFF, 1'b0);
    dir_op(REQ_PUT, 32'h0, 1'b0);
    dir_op(REQ_PUT, 32'hA5A5_A5A5, 1'b1);
    dir_op(REQ_GET, 32'h0, 1'b0);
    dir_op(REQ_GET, 32'h0, 1'b0);
    dir_chk(REQ_GET, 32'h0, 1'b0, ST_DONE, '0, 1'b1, 0, 1, ACT_NONE);
    dir_cfg(CFG_CAPACITY, 8'd0);
    dir_op(REQ_PUT, 32'h1234_5678, 1'b0);
    dir_chk(REQ_PUT, 32'hFFFF_FFFF, 1'b0, ST_FULL, '0, 1'b0, 100, 1, ACT_NONE);
    dir_chk(REQ_TICK, 32'h0, 1'b0, ST_DONE, '0, 1'b0, 100, 2, ACT_ADD);
    dir_op(REQ_TICK, 32'h0, 1'b0);
    dir_op(REQ_TICK, 32'h0, 1'b0);
    dir_op(REQ_TICK, 32'h0, 1'b0);
    dir_cfg(CFG_GROW, 8'd100);
    dir_cfg(CFG_SHRINK, 8'd127);
    dir_chk(REQ_TICK, 32'h0, 1'b0, ST_FULL, '0, 1'b0, 100, 4, ACT_NONE);
    dir_op(REQ_GET, 32'h0, 1'b0);
    dir_chk(REQ_TICK, 32'h0, 1'b0, ST_DONE, '0, 1'b0, 100, 3, ACT_REMOVE);
    dir_chk(REQ_GET, 32'h0, 1'b0, ST_DONE, '0, 1'b1, 0, 3, ACT_NONE);
    dir_cfg(CFG_CAPACITY, 8'hFF);
    dir_cfg(CFG_WRK_LOW, 8'd255);
    dir_cfg(CFG_WRK_HIGH, 8'd255);
    dir_cfg(CFG_GROW, 8'd0);
    dir_cfg(CFG_SHRINK, 8'd0);
    dir_chk(REQ_TICK, 32'h0, 1'b0, ST_DONE, '0, 1'b0, 0, 255, ACT_NONE);
    dir_op(REQ_PUT, 32'h8000_0001, 1'b0);
    dir_op(REQ_TICK, 32'h0, 1'b0);
    dir_cfg(CFG_WRK_LOW, 8'd1);
    dir_op(REQ_TICK, 32'h0, 1'b0);
    dir_cfg(CFG_WRK_LOW, 8'd200);
    dir_cfg(CFG_WRK_HIGH, 8'd3);
    dir_op(REQ_TICK, 32'h0, 1'b0);
    dir_op(REQ_GET, 32'h0, 1'b0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_req(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < 14; ph++) begin
      if (ph < 5) begin
        src_idle_pct = 30;
        snk_idle_pct = 82;
      end else if (ph < 10) begin
        src_idle_pct = 82;
        snk_idle_pct = 30;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      settle();
      if (ph == 0) begin
        v_cap = 8'd1;
        v_low = 8'd1;
        v_high = 8'd1;
        v_grow = 8'd0;
        v_shrink = 8'd0;
      end else if (ph == 1) begin
        v_cap = 8'd16;
        v_low = 8'd255;
        v_high = 8'd255;
        v_grow = 8'd100;
        v_shrink = 8'd100;
      end else begin
        v_cap = ($urandom_range(3) == 0) ? 8'd16 : CFG_DATA_W'($urandom_range(1, 8));
        v_low = CFG_DATA_W'($urandom_range(1, 4));
        v_high = CFG_DATA_W'($urandom_range(1, 10));
        v_grow = CFG_DATA_W'($urandom_range(0, 100));
        v_shrink = CFG_DATA_W'($urandom_range(0, 100));
      end
      write_reg(CFG_CAPACITY, v_cap);
      write_reg(CFG_WRK_LOW, v_low);
      write_reg(CFG_WRK_HIGH, v_high);
      write_reg(CFG_GROW, v_grow);
      write_reg(CFG_SHRINK, v_shrink);
      // result side backs up while requests keep coming
      if (ph == 2 || ph == 9) hold_len = HOLD_CYCLES;
      repeat (100) begin
        if (burst_left == 0) begin
          mode = $urandom_range(2);
          burst_left = $urandom_range(4, 20);
        end
        burst_left--;
        push_req(random_request(mode), 1'b0, blank);
      end
    end

    settle();
    $display("tb: %0d requests, %0d result beats checked, %0d register writes",
             requests_sent, results_seen, reg_writes);
    $display("tb: full puts %0d, empty gets %0d, grows %0d, shrinks %0d, no-room ticks %0d",
             n_full, n_empty, n_add, n_remove, n_no_room);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
